// ===== src/pipt_pkg.sv =====
package pipt_pkg;

    // Default coordinate width of points and configuration registers.
    localparam int COORD_BITS_DEF = 24;

    // Output beat width: the verdict padded to a whole byte.
    localparam int VERDICT_BITS  = 2;
    localparam int OUT_TDATA_W   = 8;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_X  = 2'd0,
        CFG_SOURCE_Y  = 2'd1,
        CFG_RAY_END_X = 2'd2,
        CFG_RAY_END_Y = 2'd3
    } cfg_index_t;

    // Final answer for one polygon.
    typedef enum logic [VERDICT_BITS-1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INSIDE    = 2'd1,
        VERDICT_AMBIGUOUS = 2'd2
    } verdict_t;

    // Outcome of testing one edge against the ray.
    typedef enum logic [1:0] {
        EDGE_MISS  = 2'd0,
        EDGE_CROSS = 2'd1,
        EDGE_AMBIG = 2'd2,
        EDGE_ON    = 2'd3
    } edge_class_t;

    // Sign of an orientation determinant.
    typedef struct packed {
        logic neg;
        logic zero;
    } sign_t;

endpackage

// ===== src/point_in_polygon_ray_test.sv =====
// Channel   Dir  Beat contents
// s_axis    in   tdata: vertex_x, vertex_y (low bits up); tlast: last_vertex
// m_axis    out  tdata: verdict (bits 1:0); one beat per polygon
// cfg       in   cfg_we, cfg_index, cfg_data: source and ray end coordinates
//
// One vertex is taken every cycle unless the block stalls (see below); the
// verdict of a loop passes through the input register, the product register
// inside each orientation unit and the result register.
// Vertices keep flowing while a verdict waits; only a second last vertex
// stalls behind an untaken verdict. Reset clears the control and configuration state; payload registers are not reset.
module point_in_polygon_ray_test #(
    parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // vertex_x, vertex_y, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]           s_axis_tdata,
    input  logic                                        s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // verdict, zero pad
    output logic [pipt_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,
    input  logic                                        cfg_we,
    input  logic [pipt_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [COORD_BITS-1:0]                       cfg_data
);
    import pipt_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Configuration registers.
    coord_t source_x_reg, source_y_reg, ray_end_x_reg, ray_end_y_reg;

    // Loop tracking at the input.
    coord_t first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic   have_first_reg;

    // Stage 1: the vertex and the edge endpoints that go with it.
    logic   s1_valid_reg, s1_last_reg, s1_edge1_reg;
    coord_t v_x_reg, v_y_reg, a_x_reg, a_y_reg, f_x_reg, f_y_reg;

    // Stage 2: registered products (inside the orientation units) and flags.
    logic   s2_valid_reg, s2_last_reg, s2_edge1_reg;
    logic   eq_a_reg, eq_b_reg, in_sa_reg, in_ea_reg, in_sb_reg, in_eb_reg;

    // Loop verdict state.
    logic     parity_reg, decided_reg;
    verdict_t verdict_reg;

    // Result register.
    logic     out_valid_reg;
    verdict_t out_verdict_reg;

    logic     in_accept, s1_adv, s2_adv;
    coord_t   in_x, in_y, first_eff_x, first_eff_y;
    sign_t    o_v, o_a, o_f, s0_a, s1_a, s0_b, s1_b;
    edge_class_t class_a, class_b;
    logic     dec1, dec2, par1, par2;
    verdict_t ver1, ver2, result;

    function automatic logic in_box(input coord_t px, input coord_t py,
                                    input coord_t ax, input coord_t ay,
                                    input coord_t bx, input coord_t by);
        logic in_x_range, in_y_range;
        in_x_range = (ax < bx) ? (px >= ax && px <= bx) : (px >= bx && px <= ax);
        in_y_range = (ay < by) ? (py >= ay && py <= by) : (py >= by && py <= ay);
        return in_x_range && in_y_range;
    endfunction

    function automatic edge_class_t classify(input logic src_on_end,
                                             input sign_t o1, input sign_t o2,
                                             input sign_t s0, input sign_t s1,
                                             input logic src_in, input logic end_in);
        edge_class_t c;
        if (src_on_end)
            c = EDGE_ON;
        else if (o1.zero || o2.zero)
            c = EDGE_AMBIG;
        else if (o1.neg == o2.neg)
            c = EDGE_MISS;
        else if (s0.zero && src_in)
            c = EDGE_ON;
        else if (s1.zero)
            c = end_in ? EDGE_CROSS : EDGE_MISS;
        else if (s0.zero)
            c = EDGE_MISS;
        else
            c = (s0.neg != s1.neg) ? EDGE_CROSS : EDGE_MISS;
        return c;
    endfunction

    // Handshake and pipeline advance.
    assign s2_adv        = s2_valid_reg && (!s2_last_reg || !out_valid_reg || m_axis_tready);
    assign s1_adv        = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_x        = coord_t'(s_axis_tdata[COORD_BITS-1:0]);
    assign in_y        = coord_t'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign first_eff_x = have_first_reg ? first_x_reg : in_x;
    assign first_eff_y = have_first_reg ? first_y_reg : in_y;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_x_reg  <= '0;
            source_y_reg  <= '0;
            ray_end_x_reg <= '0;
            ray_end_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_X:  source_x_reg  <= coord_t'(cfg_data);
                CFG_SOURCE_Y:  source_y_reg  <= coord_t'(cfg_data);
                CFG_RAY_END_X: ray_end_x_reg <= coord_t'(cfg_data);
                CFG_RAY_END_Y: ray_end_y_reg <= coord_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // Control state: valids, loop tracking, verdict state, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            parity_reg     <= 1'b0;
            decided_reg    <= 1'b0;
            verdict_reg    <= VERDICT_OUTSIDE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
                have_first_reg <= !s_axis_tlast;

            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            // The loop state re-arms once the last vertex is scored.
            if (s2_adv)
            begin
                if (s2_last_reg)
                begin
                    parity_reg  <= 1'b0;
                    decided_reg <= 1'b0;
                    verdict_reg <= VERDICT_OUTSIDE;
                end
                else
                begin
                    parity_reg  <= par2;
                    decided_reg <= dec2;
                    verdict_reg <= ver2;
                end
            end

            if (s2_adv && s2_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (!have_first_reg)
            begin
                first_x_reg <= in_x;
                first_y_reg <= in_y;
            end
            prev_x_reg   <= in_x;
            prev_y_reg   <= in_y;
            v_x_reg      <= in_x;
            v_y_reg      <= in_y;
            a_x_reg      <= prev_x_reg;
            a_y_reg      <= prev_y_reg;
            f_x_reg      <= first_eff_x;
            f_y_reg      <= first_eff_y;
            s1_edge1_reg <= have_first_reg;
            s1_last_reg  <= s_axis_tlast;
        end

        if (s1_adv)
        begin
            s2_edge1_reg <= s1_edge1_reg;
            s2_last_reg  <= s1_last_reg;
            eq_a_reg  <= (source_x_reg == a_x_reg && source_y_reg == a_y_reg)
                      || (source_x_reg == v_x_reg && source_y_reg == v_y_reg);
            eq_b_reg  <= (source_x_reg == v_x_reg && source_y_reg == v_y_reg)
                      || (source_x_reg == f_x_reg && source_y_reg == f_y_reg);
            in_sa_reg <= in_box(source_x_reg, source_y_reg, a_x_reg, a_y_reg,
                                v_x_reg, v_y_reg);
            in_ea_reg <= in_box(ray_end_x_reg, ray_end_y_reg, a_x_reg, a_y_reg,
                                v_x_reg, v_y_reg);
            in_sb_reg <= in_box(source_x_reg, source_y_reg, v_x_reg, v_y_reg,
                                f_x_reg, f_y_reg);
            in_eb_reg <= in_box(ray_end_x_reg, ray_end_y_reg, v_x_reg, v_y_reg,
                                f_x_reg, f_y_reg);
        end

        if (s2_adv && s2_last_reg)
            out_verdict_reg <= result;
    end

    // Side of the ray line for the new vertex, the previous one and the first.
    pipt_orient #(.COORD_BITS(COORD_BITS)) u_orient_v (
        .clk(clk), .en(s1_adv),
        .p_x(source_x_reg), .p_y(source_y_reg), .q_x(ray_end_x_reg), .q_y(ray_end_y_reg),
        .r_x(v_x_reg), .r_y(v_y_reg), .sgn(o_v)
    );
    pipt_orient #(.COORD_BITS(COORD_BITS)) u_orient_a (
        .clk(clk), .en(s1_adv),
        .p_x(source_x_reg), .p_y(source_y_reg), .q_x(ray_end_x_reg), .q_y(ray_end_y_reg),
        .r_x(a_x_reg), .r_y(a_y_reg), .sgn(o_a)
    );
    pipt_orient #(.COORD_BITS(COORD_BITS)) u_orient_f (
        .clk(clk), .en(s1_adv),
        .p_x(source_x_reg), .p_y(source_y_reg), .q_x(ray_end_x_reg), .q_y(ray_end_y_reg),
        .r_x(f_x_reg), .r_y(f_y_reg), .sgn(o_f)
    );

    // Side of each edge line for the source and the ray end.
    pipt_orient #(.COORD_BITS(COORD_BITS)) u_orient_s0a (
        .clk(clk), .en(s1_adv),
        .p_x(source_x_reg), .p_y(source_y_reg), .q_x(a_x_reg), .q_y(a_y_reg),
        .r_x(v_x_reg), .r_y(v_y_reg), .sgn(s0_a)
    );
    pipt_orient #(.COORD_BITS(COORD_BITS)) u_orient_s1a (
        .clk(clk), .en(s1_adv),
        .p_x(ray_end_x_reg), .p_y(ray_end_y_reg), .q_x(a_x_reg), .q_y(a_y_reg),
        .r_x(v_x_reg), .r_y(v_y_reg), .sgn(s1_a)
    );
    pipt_orient #(.COORD_BITS(COORD_BITS)) u_orient_s0b (
        .clk(clk), .en(s1_adv),
        .p_x(source_x_reg), .p_y(source_y_reg), .q_x(v_x_reg), .q_y(v_y_reg),
        .r_x(f_x_reg), .r_y(f_y_reg), .sgn(s0_b)
    );
    pipt_orient #(.COORD_BITS(COORD_BITS)) u_orient_s1b (
        .clk(clk), .en(s1_adv),
        .p_x(ray_end_x_reg), .p_y(ray_end_y_reg), .q_x(v_x_reg), .q_y(v_y_reg),
        .r_x(f_x_reg), .r_y(f_y_reg), .sgn(s1_b)
    );

    // Edge outcomes: the edge into the new vertex, then the closing edge.
    assign class_a = classify(eq_a_reg, o_a, o_v, s0_a, s1_a, in_sa_reg, in_ea_reg);
    assign class_b = classify(eq_b_reg, o_v, o_f, s0_b, s1_b, in_sb_reg, in_eb_reg);

    // Fold both edges into the parity and the sticky decision, in order.
    always_comb
    begin
        dec1 = decided_reg;
        ver1 = verdict_reg;
        par1 = parity_reg;
        if (s2_edge1_reg && !decided_reg)
        begin
            case (class_a)
                EDGE_CROSS: par1 = !parity_reg;
                EDGE_AMBIG:
                begin
                    dec1 = 1'b1;
                    ver1 = VERDICT_AMBIGUOUS;
                end
                EDGE_ON:
                begin
                    dec1 = 1'b1;
                    ver1 = VERDICT_INSIDE;
                end
                default: ;
            endcase
        end

        dec2 = dec1;
        ver2 = ver1;
        par2 = par1;
        if (s2_last_reg && !dec1)
        begin
            case (class_b)
                EDGE_CROSS: par2 = !par1;
                EDGE_AMBIG:
                begin
                    dec2 = 1'b1;
                    ver2 = VERDICT_AMBIGUOUS;
                end
                EDGE_ON:
                begin
                    dec2 = 1'b1;
                    ver2 = VERDICT_INSIDE;
                end
                default: ;
            endcase
        end

        if (dec2)
            result = ver2;
        else
            result = par2 ? VERDICT_INSIDE : VERDICT_OUTSIDE;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_verdict_reg);

    // A scored last vertex always leaves a verdict waiting.
    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && s2_last_reg) |=> m_axis_tvalid)
        else $error("last vertex scored without a verdict");

    // The loop state is clear after the last vertex is scored.
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && s2_last_reg) |=> (!parity_reg && !decided_reg))
        else $error("loop state not re-armed");

    // A decision stays until the polygon ends.
    a_decided_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (decided_reg && !(s2_adv && s2_last_reg)) |=> decided_reg)
        else $error("decision lost mid-loop");

    // A last vertex at the input starts a new loop.
    a_input_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tlast) |=> !have_first_reg)
        else $error("first vertex not released after last vertex");

    // Only the three defined verdicts leave the block.
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == VERDICT_OUTSIDE
            || m_axis_tdata[1:0] == VERDICT_INSIDE
            || m_axis_tdata[1:0] == VERDICT_AMBIGUOUS))
        else $error("undefined verdict code");

endmodule

// ===== src/pipt_orient.sv =====
// Exact orientation sign of the triangle (p, q, r).
// The two cross products are registered; the sign comes from their difference.
module pipt_orient #(
    parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] p_x,
    input  logic signed [COORD_BITS-1:0] p_y,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    input  logic signed [COORD_BITS-1:0] r_x,
    input  logic signed [COORD_BITS-1:0] r_y,
    output pipt_pkg::sign_t              sgn
);
    import pipt_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;

    logic signed [DIFF_W-1:0] dqx, dqy, drx, dry;
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic signed [PROD_W:0]   det;

    // Coordinate differences relative to p.
    assign dqx = DIFF_W'(q_x) - DIFF_W'(p_x);
    assign dqy = DIFF_W'(q_y) - DIFF_W'(p_y);
    assign drx = DIFF_W'(r_x) - DIFF_W'(p_x);
    assign dry = DIFF_W'(r_y) - DIFF_W'(p_y);

    // One multiplier per product, registered.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= dqx * dry;
            prod_b_reg <= dqy * drx;
        end
    end

    // Determinant and its sign.
    assign det      = (PROD_W+1)'(prod_a_reg) - (PROD_W+1)'(prod_b_reg);
    assign sgn.neg  = det[PROD_W];
    assign sgn.zero = (det == '0);

endmodule

// ===== tb/point_in_polygon_ray_test_tb.sv =====
`timescale 1ns / 100ps

module point_in_polygon_ray_test_tb;

    import pipt_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int IN_W        = ((2 * CW + 7) / 8) * 8;
    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_BEATS = 1200;

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t C_MIN = coord_t'(-8388608);
    localparam coord_t C_MAX = coord_t'(8388607);

    // Even-odd verdict predictor and the queue of verdicts still owed by the block.
    class verdict_scoreboard;
        longint src_x, src_y, end_x, end_y;
        longint first_x, first_y, prev_x, prev_y;
        bit have_first, parity, decided;
        verdict_t held_verdict;
        verdict_t verdicts_due[$];

        function new();
            src_x = 0;
            src_y = 0;
            end_x = 0;
            end_y = 0;
            rearm();
        endfunction

        function void rearm();
            first_x = 0;
            first_y = 0;
            prev_x = 0;
            prev_y = 0;
            have_first = 0;
            parity = 0;
            decided = 0;
            held_verdict = VERDICT_OUTSIDE;
        endfunction

        function void set_reg(cfg_index_t idx, coord_t v);
            case (idx)
                CFG_SOURCE_X:  src_x = longint'(v);
                CFG_SOURCE_Y:  src_y = longint'(v);
                CFG_RAY_END_X: end_x = longint'(v);
                CFG_RAY_END_Y: end_y = longint'(v);
                default: ;
            endcase
        endfunction

        // Sign of the cross product (q - p) x (r - p); fits easily in 64 bits.
        function int orient(longint px, longint py, longint qx, longint qy,
                            longint rx, longint ry);
            longint det;
            det = (qx - px) * (ry - py) - (qy - py) * (rx - px);
            return (det > 0) ? 1 : ((det < 0) ? -1 : 0);
        endfunction

        function bit in_box(longint px, longint py, longint ax, longint ay,
                            longint bx, longint by);
            return (px >= ((ax < bx) ? ax : bx)) && (px <= ((ax < bx) ? bx : ax)) &&
                   (py >= ((ay < by) ? ay : by)) && (py <= ((ay < by) ? by : ay));
        endfunction

        function edge_class_t classify_edge(longint ax, longint ay, longint bx, longint by);
            int o_a, o_b, s_src, s_end;
            if ((src_x == ax && src_y == ay) || (src_x == bx && src_y == by))
                return EDGE_ON;
            o_a = orient(src_x, src_y, end_x, end_y, ax, ay);
            o_b = orient(src_x, src_y, end_x, end_y, bx, by);
            if (o_a * o_b > 0)
                return EDGE_MISS;
            if (o_a * o_b == 0)
                return EDGE_AMBIG;
            // Both ends straddle the ray line; now look at the edge line.
            s_src = orient(src_x, src_y, ax, ay, bx, by);
            if (s_src == 0 && in_box(src_x, src_y, ax, ay, bx, by))
                return EDGE_ON;
            s_end = orient(end_x, end_y, ax, ay, bx, by);
            if (s_end == 0)
                return in_box(end_x, end_y, ax, ay, bx, by) ? EDGE_CROSS : EDGE_MISS;
            if (s_src == 0)
                return EDGE_MISS;
            return (s_src * s_end < 0) ? EDGE_CROSS : EDGE_MISS;
        endfunction

        function void apply_edge(longint ax, longint ay, longint bx, longint by);
            edge_class_t c;
            if (decided)
                return;
            c = classify_edge(ax, ay, bx, by);
            case (c)
                EDGE_CROSS: parity = !parity;
                EDGE_AMBIG:
                begin
                    decided = 1;
                    held_verdict = VERDICT_AMBIGUOUS;
                end
                EDGE_ON:
                begin
                    decided = 1;
                    held_verdict = VERDICT_INSIDE;
                end
                default: ;
            endcase
        endfunction

        // Notes one accepted vertex beat; the last vertex closes the loop.
        function void take_vertex(coord_t x, coord_t y, bit last);
            longint vx, vy;
            verdict_t owed;
            vx = longint'(x);
            vy = longint'(y);
            if (have_first)
                apply_edge(prev_x, prev_y, vx, vy);
            else
            begin
                first_x = vx;
                first_y = vy;
                have_first = 1;
            end
            prev_x = vx;
            prev_y = vy;
            if (last)
            begin
                apply_edge(vx, vy, first_x, first_y);
                owed = decided ? held_verdict :
                       (parity ? VERDICT_INSIDE : VERDICT_OUTSIDE);
                verdicts_due = {verdicts_due, owed};
                rearm();
            end
        endfunction

        // Compares a delivered verdict with the oldest one owed.
        function bit match_verdict(input verdict_t got, output bit had, output verdict_t want);
            had = (verdicts_due.size() != 0);
            want = VERDICT_OUTSIDE;
            if (!had)
                return 0;
            want = verdicts_due.pop_front();
            return got == want;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic            s_axis_tlast = 1'b0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic            cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CW-1:0]   cfg_data = '0;

    verdict_scoreboard sb = new();
    int  error_count = 0;
    int  beats_sent = 0;
    int  quiet_cycles = 0;
    bit  send_calm = 0;
    bit  recv_calm = 0;

    point_in_polygon_ray_test #(.COORD_BITS(CW)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Idle cycles before the next beat; occasionally switch into or out of a calm stretch.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 23) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic coord_t rand_wide();
        case ($urandom_range(0, 9))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return coord_t'(-1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic coord_t near(coord_t base, int span);
        return coord_t'(longint'(base) + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Drives one vertex beat and holds it until the block takes it.
    task automatic send_vertex(input coord_t x, input coord_t y, input bit last);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata = '0;
        s_axis_tdata[CW-1:0] = x;
        s_axis_tdata[2*CW-1:CW] = y;
        s_axis_tlast = last;
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.take_vertex(x, y, last);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input coord_t v);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_ray(input coord_t sx, input coord_t sy, input coord_t ex,
                             input coord_t ey);
        write_reg(CFG_SOURCE_X, sx);
        write_reg(CFG_SOURCE_Y, sy);
        write_reg(CFG_RAY_END_X, ex);
        write_reg(CFG_RAY_END_Y, ey);
    endtask

    // Stops sending and lets every owed verdict drain before touching registers.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        s_axis_tlast = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Verdict sink with random back-pressure.
    initial
    begin
        int gap;
        bit had;
        verdict_t got, want;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(recv_calm);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got = verdict_t'(m_axis_tdata[VERDICT_BITS-1:0]);
            if (!sb.match_verdict(got, had, want))
            begin
                if (!had)
                    report_mismatch($sformatf("verdict %0d arrived with none expected", got));
                else
                    report_mismatch($sformatf("verdict %0d, expected %0d", got, want));
            end
            @(negedge clk);
        end
    end

    // Watchdog: ends the run if no beat or register write happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Stimulus: directed polygons first, then random ray settings and polygons.
    initial
    begin
        int mode, npoly, nverts;
        coord_t bx, by, sx, sy, ex, ey, vx, vy;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Source equals ray end after reset, single vertex loop.
        send_vertex(coord_t'(5), coord_t'(3), 1'b1);
        drain();

        write_ray('0, '0, coord_t'(1000), coord_t'(3));
        // Square around the source.
        send_vertex(coord_t'(-10), coord_t'(-10), 1'b0);
        send_vertex(coord_t'(10), coord_t'(-10), 1'b0);
        send_vertex(coord_t'(10), coord_t'(10), 1'b0);
        send_vertex(coord_t'(-10), coord_t'(10), 1'b1);
        // Source sits on a vertex.
        send_vertex(coord_t'(0), coord_t'(0), 1'b0);
        send_vertex(coord_t'(5), coord_t'(0), 1'b0);
        send_vertex(coord_t'(0), coord_t'(5), 1'b1);
        // Source sits inside an edge.
        send_vertex(coord_t'(-5), coord_t'(0), 1'b0);
        send_vertex(coord_t'(5), coord_t'(0), 1'b0);
        send_vertex(coord_t'(0), coord_t'(5), 1'b1);
        // Ray touches a vertex.
        send_vertex(coord_t'(500), coord_t'(-20), 1'b0);
        send_vertex(coord_t'(1000), coord_t'(3), 1'b0);
        send_vertex(coord_t'(500), coord_t'(20), 1'b1);
        drain();

        // Extreme coordinates, and an edge with equal ends.
        write_ray('0, '0, C_MAX, C_MIN);
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MAX, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);
        send_vertex(coord_t'(3), coord_t'(-5), 1'b0);
        send_vertex(coord_t'(3), coord_t'(-5), 1'b0);
        send_vertex(coord_t'(-3), coord_t'(5), 1'b1);
        drain();

        // Random phases: a ray setting, then a handful of polygons.
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            mode = $urandom_range(0, 3);
            bx = rand_wide();
            by = rand_wide();
            if (mode == 0)
            begin
                sx = rand_wide();
                sy = rand_wide();
                ex = rand_wide();
                ey = rand_wide();
            end
            else
            begin
                // Tight grid around a base point: collinear and touching cases are common.
                sx = near(bx, 2);
                sy = near(by, 2);
                ex = near(bx, 12);
                ey = near(by, 12);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                ex = sx;
                ey = sy;
            end
            write_ray(sx, sy, ex, ey);

            npoly = $urandom_range(1, 6);
            repeat (npoly)
            begin
                nverts = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                     : $urandom_range(1, 8);
                for (int i = 0; i < nverts; i++)
                begin
                    if (mode == 0)
                    begin
                        vx = rand_wide();
                        vy = rand_wide();
                    end
                    else
                    begin
                        vx = near(bx, 8);
                        vy = near(by, 8);
                    end
                    send_vertex(vx, vy, i == nverts - 1);
                end
            end
            drain();
        end

        // All beats sent: wait out owed verdicts, then watch for strays.
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
src/pipt_pkg.sv
src/pipt_orient.sv
src/point_in_polygon_ray_test.sv
tb/point_in_polygon_ray_test_tb.sv
